// File: rtl/pqtr_pkg.sv
`timescale 1ns / 1ps
package pqtr_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int MS_PER_S = 1000;

   localparam logic [1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [1:0] ACT_DEQUEUE = 2'd1;
   localparam logic [1:0] ACT_REQUEUE = 2'd2;
   localparam logic [1:0] ACT_PURGE   = 2'd3;

   localparam logic [2:0] ST_QUEUED     = 3'd0;
   localparam logic [2:0] ST_FULL_DROP  = 3'd1;
   localparam logic [2:0] ST_DEQUEUED   = 3'd2;
   localparam logic [2:0] ST_EMPTY      = 3'd3;
   localparam logic [2:0] ST_REQUEUED   = 3'd4;
   localparam logic [2:0] ST_RETRY_DROP = 3'd5;
   localparam logic [2:0] ST_REQ_FULL   = 3'd6;
   localparam logic [2:0] ST_PURGED     = 3'd7;

   localparam logic [2:0] CSR_LIFE_URGENT = 3'd0;
   localparam logic [2:0] CSR_LIFE_HIGH   = 3'd1;
   localparam logic [2:0] CSR_LIFE_NORMAL = 3'd2;
   localparam logic [2:0] CSR_LIFE_LOW    = 3'd3;
   localparam logic [2:0] CSR_RETRY_LIMIT = 3'd4;

   localparam logic [23:0] LIFE_URGENT_RST = 24'd86400;
   localparam logic [23:0] LIFE_HIGH_RST   = 24'd43200;
   localparam logic [23:0] LIFE_NORMAL_RST = 24'd21600;
   localparam logic [23:0] LIFE_LOW_RST    = 24'd3600;
   localparam logic [1:0]  RETRY_LIMIT_RST = 2'd3;

   typedef struct packed {
      logic [31:0] tag;
      logic [7:0]  prio;
      logic [31:0] arrival;
      logic [23:0] life;
      logic [1:0]  retries;
   } entry_type;

endpackage

// File: rtl/priority_queue_ttl_retry_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake            Payload
// req      in   req_tvalid/tready    action, now, source, packet time, prio, tag,
//                                    retries, arrival, life
// rsp      out  rsp_tvalid/tready    status, entry fields, occupancy, removed count
// csr      in   csr_we               csr_addr, csr_wdata
// Enqueue, requeue and empty cases go from S_IDLE straight to S_DONE; dequeue
// passes S_SCAN and S_SHIFT, purge S_PURGE, paced by the registered-read entry
// memory (one read and one write per cycle). Synchronous reset empties the queue.
// A result waits in the rsp register; the next transfer on req is taken meanwhile,
// and only the final load of a result stalls on rsp_tready.
module priority_queue_ttl_retry_unit #(
   parameter int QUEUE_DEPTH = pqtr_pkg::DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action, now_ms, source_node, packet_time, prio_in, tag_in, retries_in,
   // arrival_in, life_in, zero pad
   input  logic [199:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, tag_out, prio_out, retries_out, arrival_out, life_out,
   // occupancy, removed_count, zero pad
   output logic [111:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [23:0]  csr_wdata
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_SHIFT = 5'b00100,
      S_PURGE = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   logic [1:0]  in_action;
   logic [31:0] in_now, in_src, in_ptime, in_tag, in_arr;
   logic [7:0]  in_prio;
   logic [1:0]  in_retries;
   logic [23:0] in_life;

   assign in_action  = req_tdata[1:0];
   assign in_now     = req_tdata[33:2];
   assign in_src     = req_tdata[65:34];
   assign in_ptime   = req_tdata[97:66];
   assign in_prio    = req_tdata[105:98];
   assign in_tag     = req_tdata[137:106];
   assign in_retries = req_tdata[139:138];
   assign in_arr     = req_tdata[171:140];
   assign in_life    = req_tdata[195:172];

   logic [23:0] life_urgent_ff, life_high_ff, life_normal_ff, life_low_ff;
   logic [1:0]  retry_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         life_urgent_ff <= pqtr_pkg::LIFE_URGENT_RST;
         life_high_ff   <= pqtr_pkg::LIFE_HIGH_RST;
         life_normal_ff <= pqtr_pkg::LIFE_NORMAL_RST;
         life_low_ff    <= pqtr_pkg::LIFE_LOW_RST;
         retry_limit_ff <= pqtr_pkg::RETRY_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            pqtr_pkg::CSR_LIFE_URGENT: life_urgent_ff <= csr_wdata;
            pqtr_pkg::CSR_LIFE_HIGH:   life_high_ff   <= csr_wdata;
            pqtr_pkg::CSR_LIFE_NORMAL: life_normal_ff <= csr_wdata;
            pqtr_pkg::CSR_LIFE_LOW:    life_low_ff    <= csr_wdata;
            pqtr_pkg::CSR_RETRY_LIMIT: retry_limit_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   pqtr_pkg::entry_type mem [QUEUE_DEPTH];
   pqtr_pkg::entry_type rd_q_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_wa, mem_ra;
   pqtr_pkg::entry_type mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_q_ff <= mem[mem_ra];
   end

   state_type           state_ff, state_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [CW-1:0]       iss_ff, iss_in;
   logic                vld_ff, vld_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       best_ff, best_in;
   pqtr_pkg::entry_type best_e_ff, best_e_in;
   logic [CW-1:0]       keep_ff, keep_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic [2:0]          stat_ff, stat_in;
   logic [31:0]         now_ff, now_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [111:0]        rsp_data_ff, rsp_data_in;

   logic [23:0]  life_sel;
   logic [31:0]  age_ms;
   logic [34:0]  thresh;
   logic         expired;
   logic         take_best;
   logic [AW-1:0] best_next;
   logic         full;
   logic         issue;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign full       = (fill_ff == CW'(QUEUE_DEPTH));
   assign issue      = (iss_ff < fill_ff);
   assign mem_ra     = AW'(iss_ff);

   always_comb begin
      case (in_prio)
         8'd0:    life_sel = life_urgent_ff;
         8'd1:    life_sel = life_high_ff;
         8'd3:    life_sel = life_low_ff;
         default: life_sel = life_normal_ff;
      endcase
   end

   // age / 1000 > life  <=>  age >= (life + 1) * 1000
   assign age_ms  = now_ff - rd_q_ff.arrival;
   assign thresh  = 35'(({1'b0, rd_q_ff.life} + 25'd1) * 10'(pqtr_pkg::MS_PER_S));
   assign expired = ({3'b000, age_ms} >= thresh);

   assign take_best = (idx_ff == '0) || (rd_q_ff.prio < best_e_ff.prio);
   assign best_next = take_best ? idx_ff : best_ff;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      iss_in       = iss_ff;
      vld_in       = 1'b0;
      idx_in       = idx_ff;
      best_in      = best_ff;
      best_e_in    = best_e_ff;
      keep_in      = keep_ff;
      rem_in       = rem_ff;
      stat_in      = stat_ff;
      now_in       = now_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = AW'(fill_ff);
      mem_wd       = rd_q_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               now_in   = in_now;
               rem_in   = '0;
               iss_in   = '0;
               keep_in  = '0;
               state_in = S_DONE;
               unique case (in_action)
                  pqtr_pkg::ACT_ENQUEUE: begin
                     if (full) begin
                        stat_in = pqtr_pkg::ST_FULL_DROP;
                     end else begin
                        mem_we  = 1'b1;
                        mem_wd  = '{tag: in_src ^ in_ptime, prio: in_prio,
                                    arrival: in_now, life: life_sel, retries: 2'd0};
                        fill_in = fill_ff + CW'(1);
                        stat_in = pqtr_pkg::ST_QUEUED;
                     end
                  end
                  pqtr_pkg::ACT_DEQUEUE: begin
                     if (fill_ff == '0) begin
                        stat_in = pqtr_pkg::ST_EMPTY;
                     end else begin
                        stat_in  = pqtr_pkg::ST_DEQUEUED;
                        state_in = S_SCAN;
                     end
                  end
                  pqtr_pkg::ACT_REQUEUE: begin
                     if (in_retries >= retry_limit_ff) begin
                        stat_in = pqtr_pkg::ST_RETRY_DROP;
                     end else if (full) begin
                        stat_in = pqtr_pkg::ST_REQ_FULL;
                     end else begin
                        mem_we  = 1'b1;
                        mem_wd  = '{tag: in_tag, prio: in_prio, arrival: in_arr,
                                    life: in_life, retries: in_retries + 2'd1};
                        fill_in = fill_ff + CW'(1);
                        stat_in = pqtr_pkg::ST_REQUEUED;
                     end
                  end
                  default: begin
                     stat_in = pqtr_pkg::ST_PURGED;
                     if (fill_ff != '0) begin
                        state_in = S_PURGE;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (issue) begin
               vld_in = 1'b1;
               idx_in = AW'(iss_ff);
               iss_in = iss_ff + CW'(1);
            end
            if (vld_ff) begin
               best_in = best_next;
               if (take_best) begin
                  best_e_in = rd_q_ff;
               end
               if (CW'(idx_ff) == fill_ff - CW'(1)) begin
                  iss_in   = CW'(best_next) + CW'(1);
                  vld_in   = 1'b0;
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            if (issue) begin
               vld_in = 1'b1;
               idx_in = AW'(iss_ff);
               iss_in = iss_ff + CW'(1);
            end
            if (vld_ff) begin
               mem_we = 1'b1;
               mem_wa = idx_ff - AW'(1);
            end
            if (!issue && !vld_ff) begin
               fill_in  = fill_ff - CW'(1);
               state_in = S_DONE;
            end
         end
         S_PURGE: begin
            if (issue) begin
               vld_in = 1'b1;
               idx_in = AW'(iss_ff);
               iss_in = iss_ff + CW'(1);
            end
            if (vld_ff) begin
               if (expired) begin
                  rem_in = rem_ff + CW'(1);
               end else begin
                  mem_we  = 1'b1;
                  mem_wa  = AW'(keep_ff);
                  keep_in = keep_ff + CW'(1);
               end
            end
            if (!issue && !vld_ff) begin
               fill_in  = keep_ff;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[2:0]     = stat_ff;
               if (stat_ff == pqtr_pkg::ST_DEQUEUED) begin
                  rsp_data_in[34:3]  = best_e_ff.tag;
                  rsp_data_in[42:35] = best_e_ff.prio;
                  rsp_data_in[44:43] = best_e_ff.retries;
                  rsp_data_in[76:45] = best_e_ff.arrival;
                  rsp_data_in[100:77] = best_e_ff.life;
               end
               rsp_data_in[105:101] = 5'(fill_ff);
               rsp_data_in[110:106] = 5'(rem_ff);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      iss_ff      <= iss_in;
      idx_ff      <= idx_in;
      best_ff     <= best_in;
      best_e_ff   <= best_e_in;
      keep_ff     <= keep_in;
      rem_ff      <= rem_in;
      stat_ff     <= stat_in;
      now_ff      <= now_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: verif/tb_priority_queue_ttl_retry_unit.sv
`timescale 1ns / 1ps
module tb_priority_queue_ttl_retry_unit;

   localparam int QDEPTH = pqtr_pkg::DEPTH_DEFAULT;

   typedef struct {
      logic [1:0]  action;
      logic [31:0] now_ms;
      logic [31:0] source;
      logic [31:0] ptime;
      logic [7:0]  prio;
      logic [31:0] tag;
      logic [1:0]  retries;
      logic [31:0] arrival;
      logic [23:0] life;
   } msg_req_type;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] tag;
      logic [7:0]  prio;
      logic [1:0]  retries;
      logic [31:0] arrival;
      logic [23:0] life;
      logic [4:0]  occupancy;
      logic [4:0]  removed;
   } msg_rsp_type;

   class queue_scoreboard;
      logic [23:0]         life_reg[4];
      logic [1:0]          retry_lim;
      pqtr_pkg::entry_type slots[QDEPTH];
      int                  fill;
      msg_rsp_type         expected_rsp[$];
      int                  errors;

      function new();
         life_reg[0] = pqtr_pkg::LIFE_URGENT_RST;
         life_reg[1] = pqtr_pkg::LIFE_HIGH_RST;
         life_reg[2] = pqtr_pkg::LIFE_NORMAL_RST;
         life_reg[3] = pqtr_pkg::LIFE_LOW_RST;
         retry_lim = pqtr_pkg::RETRY_LIMIT_RST;
         fill = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] addr, logic [23:0] val);
         case (addr)
            pqtr_pkg::CSR_LIFE_URGENT: life_reg[0] = val;
            pqtr_pkg::CSR_LIFE_HIGH:   life_reg[1] = val;
            pqtr_pkg::CSR_LIFE_NORMAL: life_reg[2] = val;
            pqtr_pkg::CSR_LIFE_LOW:    life_reg[3] = val;
            pqtr_pkg::CSR_RETRY_LIMIT: retry_lim = val[1:0];
            default: ;
         endcase
      endfunction

      function logic [23:0] lifetime_for(logic [7:0] p);
         case (p)
            8'd0: return life_reg[0];
            8'd1: return life_reg[1];
            8'd3: return life_reg[3];
            default: return life_reg[2];
         endcase
      endfunction

      function void note_request(msg_req_type m);
         msg_rsp_type r;
         int best, keep;
         logic [31:0] age;
         r = '{default: '0};
         case (m.action)
            pqtr_pkg::ACT_ENQUEUE: begin
               if (fill >= QDEPTH) begin
                  r.status = pqtr_pkg::ST_FULL_DROP;
               end else begin
                  slots[fill] = '{m.source ^ m.ptime, m.prio, m.now_ms,
                                  lifetime_for(m.prio), 2'd0};
                  fill++;
                  r.status = pqtr_pkg::ST_QUEUED;
               end
            end
            pqtr_pkg::ACT_DEQUEUE: begin
               if (fill == 0) begin
                  r.status = pqtr_pkg::ST_EMPTY;
               end else begin
                  best = 0;
                  for (int i = 1; i < fill; i++)
                     if (slots[i].prio < slots[best].prio) best = i;
                  r.tag = slots[best].tag;
                  r.prio = slots[best].prio;
                  r.retries = slots[best].retries;
                  r.arrival = slots[best].arrival;
                  r.life = slots[best].life;
                  for (int i = best; i + 1 < fill; i++) slots[i] = slots[i + 1];
                  fill--;
                  r.status = pqtr_pkg::ST_DEQUEUED;
               end
            end
            pqtr_pkg::ACT_REQUEUE: begin
               if (m.retries >= retry_lim) begin
                  r.status = pqtr_pkg::ST_RETRY_DROP;
               end else if (fill >= QDEPTH) begin
                  r.status = pqtr_pkg::ST_REQ_FULL;
               end else begin
                  slots[fill] = '{m.tag, m.prio, m.arrival, m.life, m.retries + 2'd1};
                  fill++;
                  r.status = pqtr_pkg::ST_REQUEUED;
               end
            end
            default: begin
               keep = 0;
               for (int i = 0; i < fill; i++) begin
                  age = (m.now_ms - slots[i].arrival) / pqtr_pkg::MS_PER_S;
                  if (age > {8'd0, slots[i].life}) begin
                     r.removed++;
                  end else begin
                     slots[keep] = slots[i];
                     keep++;
                  end
               end
               fill = keep;
               r.status = pqtr_pkg::ST_PURGED;
            end
         endcase
         r.occupancy = fill[4:0];
         expected_rsp.push_back(r);
      endfunction

      function void check_response(logic [111:0] d);
         msg_rsp_type e;
         if (expected_rsp.size() == 0) begin
            $error("unexpected response transfer %h", d);
            errors++;
            return;
         end
         e = expected_rsp.pop_front();
         if (d[2:0] !== e.status) begin
            $error("status exp %0d got %0d", e.status, d[2:0]); errors++;
         end
         if (d[34:3] !== e.tag) begin
            $error("tag_out exp %h got %h", e.tag, d[34:3]); errors++;
         end
         if (d[42:35] !== e.prio) begin
            $error("prio_out exp %0d got %0d", e.prio, d[42:35]); errors++;
         end
         if (d[44:43] !== e.retries) begin
            $error("retries_out exp %0d got %0d", e.retries, d[44:43]); errors++;
         end
         if (d[76:45] !== e.arrival) begin
            $error("arrival_out exp %h got %h", e.arrival, d[76:45]); errors++;
         end
         if (d[100:77] !== e.life) begin
            $error("life_out exp %0d got %0d", e.life, d[100:77]); errors++;
         end
         if (d[105:101] !== e.occupancy) begin
            $error("occupancy exp %0d got %0d", e.occupancy, d[105:101]); errors++;
         end
         if (d[110:106] !== e.removed) begin
            $error("removed_count exp %0d got %0d", e.removed, d[110:106]); errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [199:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_addr = '0;
   logic [23:0]  csr_wdata = '0;

   queue_scoreboard sb = new();
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_request = 0;
   logic [31:0] clock_ms = 0;

   always #5 clock = ~clock;

   priority_queue_ttl_retry_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // response side: random stalls plus one long hold-off
   initial begin
      int hold_cnt;
      bit held;
      hold_cnt = 0;
      held = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (hold_request && !held) begin
            hold_cnt = 300;
            held = 1;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_request(msg_req_type m);
      req_tdata <= {4'd0, m.life, m.arrival, m.retries, m.tag, m.prio, m.ptime,
                    m.source, m.now_ms, m.action};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(m);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (2 * QDEPTH + 20) @(posedge clock);
   endtask

   task automatic write_lifetimes(logic [23:0] u, logic [23:0] h, logic [23:0] n,
                                  logic [23:0] l, logic [1:0] lim);
      logic [23:0] vals[5];
      logic [2:0]  addrs[5];
      vals = '{u, h, n, l, {22'd0, lim}};
      addrs = '{pqtr_pkg::CSR_LIFE_URGENT, pqtr_pkg::CSR_LIFE_HIGH,
                pqtr_pkg::CSR_LIFE_NORMAL, pqtr_pkg::CSR_LIFE_LOW,
                pqtr_pkg::CSR_RETRY_LIMIT};
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_addr <= addrs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.write_reg(addrs[i], vals[i]);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic msg_req_type make_msg(logic [1:0] act, logic [7:0] p);
      msg_req_type m;
      m.action = act;
      m.now_ms = clock_ms;
      m.source = $urandom;
      m.ptime = $urandom;
      m.prio = p;
      m.tag = $urandom;
      m.retries = 2'($urandom_range(3));
      m.arrival = ($urandom_range(9) == 0) ? $urandom : clock_ms - $urandom_range(20000);
      m.life = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(20));
      return m;
   endfunction

   function automatic logic [7:0] rand_prio();
      return ($urandom_range(9) < 7) ? 8'($urandom_range(3)) : 8'($urandom);
   endfunction

   task automatic random_items(int count);
      msg_req_type m;
      int pick;
      for (int k = 0; k < count; k++) begin
         clock_ms = ($urandom_range(199) == 0) ? $urandom
                                               : clock_ms + $urandom_range(3000);
         pick = $urandom_range(99);
         if (pick < 35)      m = make_msg(pqtr_pkg::ACT_ENQUEUE, rand_prio());
         else if (pick < 62) m = make_msg(pqtr_pkg::ACT_DEQUEUE, rand_prio());
         else if (pick < 82) m = make_msg(pqtr_pkg::ACT_REQUEUE, rand_prio());
         else                m = make_msg(pqtr_pkg::ACT_PURGE, rand_prio());
         send_request(m);
      end
   endtask

   initial begin
      msg_req_type m;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part on reset lifetimes
      send_idle_pct = 16;
      recv_stall_pct = 80;
      m = make_msg(pqtr_pkg::ACT_ENQUEUE, 8'd3);
      m.source = '1; m.ptime = '0; m.now_ms = '0;
      send_request(m);
      m = make_msg(pqtr_pkg::ACT_ENQUEUE, 8'd255);
      m.source = '0; m.ptime = '1; m.now_ms = '1;
      send_request(m);
      send_request(make_msg(pqtr_pkg::ACT_ENQUEUE, 8'd1));
      send_request(make_msg(pqtr_pkg::ACT_ENQUEUE, 8'd0));
      send_request(make_msg(pqtr_pkg::ACT_ENQUEUE, 8'd2));
      send_request(make_msg(pqtr_pkg::ACT_ENQUEUE, 8'd0));
      send_request(make_msg(pqtr_pkg::ACT_DEQUEUE, 8'd0));
      m = make_msg(pqtr_pkg::ACT_PURGE, 8'd0); m.now_ms = clock_ms;
      send_request(m);
      m.now_ms = clock_ms - 32'd1;
      send_request(m);
      send_request(make_msg(pqtr_pkg::ACT_DEQUEUE, 8'd0));
      m = make_msg(pqtr_pkg::ACT_REQUEUE, 8'd2); m.retries = 2'd3;
      send_request(m);
      m.retries = 2'd2; m.life = '1; m.arrival = '1; m.tag = '1;
      send_request(m);
      for (int i = 0; i < QDEPTH; i++)
         send_request(make_msg(pqtr_pkg::ACT_ENQUEUE, 8'd2));
      m = make_msg(pqtr_pkg::ACT_REQUEUE, 8'd0); m.retries = 2'd0;
      send_request(m);
      for (int i = 0; i < QDEPTH + 1; i++)
         send_request(make_msg(pqtr_pkg::ACT_DEQUEUE, 8'd0));
      wait_drained();

      // short lifetimes, no retries allowed
      write_lifetimes(24'd0, 24'd1, 24'd3, 24'd6, 2'd0);
      random_items(400);
      wait_drained();

      // long stall on the response side while requests keep coming
      send_idle_pct = 80;
      recv_stall_pct = 16;
      write_lifetimes('1, '1, '1, '1, 2'd1);
      hold_request = 1;
      for (int i = 0; i < 24; i++)
         send_request(make_msg(pqtr_pkg::ACT_ENQUEUE, rand_prio()));
      random_items(380);
      wait_drained();

      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_lifetimes(24'($urandom_range(30)), 24'($urandom_range(30)),
                      24'($urandom_range(30)), 24'($urandom_range(30)), 2'd2);
      random_items(400);
      wait_drained();

      write_lifetimes(24'd86400, 24'd43200, 24'd21600, 24'd3600, 2'd3);
      random_items(400);
      wait_drained();

      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
